// File: hw/rtl/windowed_geometric_median_filter_top_macros.svh
// assertion helpers for the geometric median filter
`ifndef WINDOWED_GEOMETRIC_MEDIAN_FILTER_TOP_MACROS_SVH
`define WINDOWED_GEOMETRIC_MEDIAN_FILTER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define WGMF_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WGMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/wgmf_pkg.sv
`default_nettype none
package wgmf_pkg;

  localparam int COORD_BITS  = 32;
  localparam int WEIGHT_BITS = 62 - COORD_BITS;
  localparam int WEIGHT_W    = 56;
  localparam int DIST_W      = COORD_BITS + 2;
  localparam int DIST_OP_W   = 31;
  localparam int MUL_W       = 34;
  localparam int SAT_W       = 66;
  localparam int CFG_AW      = 4;

  localparam logic [DIST_W-1:0] MIN_DIST        = DIST_W'(66);
  localparam logic [63:0]       WEIGHT_DIVIDEND = 64'h4000_0000_0000_0000;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_WINDOW_LENGTH   = 2'd0,
    REG_ITERATION_COUNT = 2'd1,
    REG_JUMP_THRESHOLD  = 2'd2
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MEAN_RD,
    ST_MEAN_ACC,
    ST_MEAN_DIV,
    ST_MEAN_WAIT,
    ST_ITER,
    ST_P1_RD,
    ST_DIST,
    ST_SQA,
    ST_SQB,
    ST_SQRT,
    ST_SQRT_WAIT,
    ST_WDIV,
    ST_WDIV_WAIT,
    ST_TSHIFT,
    ST_P2_RD,
    ST_P2_MULX,
    ST_P2_MULY,
    ST_P2_ACC,
    ST_P2_END,
    ST_STEP_DIV,
    ST_STEP_WAIT,
    ST_JUMP,
    ST_DONE
  } state_e;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
    if (&v[SAT_W-1:COORD_BITS-1] || ~|v[SAT_W-1:COORD_BITS-1]) begin
      return v[COORD_BITS-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/wgmf_in_if.sv
`default_nettype none
interface wgmf_in_if
  import wgmf_pkg::*;
;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;

  modport source (output valid, output cmd, output pos_x, output pos_y, input ready);
  modport sink (input valid, input cmd, input pos_x, input pos_y, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/wgmf_out_if.sv
`default_nettype none
interface wgmf_out_if
  import wgmf_pkg::*;
;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         jump_reset;

  modport source (output valid, output out_x, output out_y, output jump_reset, input ready);
  modport sink (input valid, input out_x, input out_y, input jump_reset, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/wgmf_div.sv
`default_nettype none
// restoring unsigned divider, one quotient bit per cycle
module wgmf_div
  import wgmf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [63:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      quotient_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [64:0] rem_q;
  logic [63:0] quo_q, dvs_q;
  logic [64:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_q[63:0], quo_q[63]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_q <= {quo_q[62:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// File: hw/rtl/wgmf_isqrt.sv
`default_nettype none
// digit-by-digit integer square root, one result bit per cycle
module wgmf_isqrt
  import wgmf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [62:0] radicand_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic        busy_q, done_q;
  logic [62:0] bit_q, v_q;
  logic [63:0] r_q;
  logic [63:0] trial;
  logic        take;

  assign trial = r_q + {1'b0, bit_q};
  assign take  = {1'b0, v_q} >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= radicand_i;
      r_q   <= '0;
      bit_q <= {1'b1, 62'b0};
    end else if (busy_q) begin
      if (take) begin
        v_q <= v_q - trial[62:0];
        r_q <= (r_q >> 1) + {1'b0, bit_q};
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule
`default_nettype wire

// File: hw/rtl/windowed_geometric_median_filter_top.sv
// Geometric median filter for 2-D pen positions in signed Q16.16 mm. Each add request writes
// its sample into a ring window and yields one result: the sample itself while it is alone in
// the window, else the window median found by the mean and then iteration_count Weiszfeld
// steps, which a jump test replaces by the sample, with the window emptied, when the sample
// lies beyond jump_threshold from the median; a clear request empties the window and yields
// nothing. The block holds one request at a time and is not ready while it works; a finished
// result waits in an output register, so the next request can be taken before it is read.
// The mean, the weights and the steps go through the shared divider, and every point of every
// iteration passes through it and the square-root unit once each. Writing window_length
// empties the window. All multiplications go through one shared multiplier.
`default_nettype none
`include "windowed_geometric_median_filter_top_macros.svh"
module windowed_geometric_median_filter_top
  import wgmf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  wgmf_in_if.sink                sample_i,
  wgmf_out_if.source             result_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  state_e state_q, state_d;

  logic [4:0]       wl_q, wl_d, iter_q, iter_d, it_q, it_d;
  logic [30:0]      thr_q, thr_d;
  logic [CNT_W-1:0] fill_q, fill_d, idx_q, idx_d, len, fill_n, slot_inc;
  logic [IDX_W-1:0] ws_q, ws_d, slot, ws_n;
  logic [5:0]       t_q, t_d;
  logic             yflag_q, yflag_d, jmode_q, jmode_d;
  logic             out_valid_q, out_valid_d, out_load;

  logic [63:0] p_q, p_d;
  logic signed [63:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic [63:0] tot_q, tot_d;
  logic [WEIGHT_BITS-1:0] wsum_q, wsum_d, ws;
  logic signed [COORD_BITS-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [COORD_BITS-1:0] res_x_q, res_x_d, res_y_q, res_y_d;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
  logic res_jump_q, res_jump_d, out_jump_q;
  logic [DIST_OP_W-1:0] da_q, da_d, db_q, db_d;
  logic [1:0] ds_q, ds_d;
  logic [61:0] sqa_q, sqa_d;
  logic [DIST_W-1:0] dist_q, dist_d, dist_new;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod_q;

  logic [63:0] win_mem [WINDOW_DEPTH];
  logic [WEIGHT_W-1:0] wgt_mem [WINDOW_DEPTH];
  logic [63:0] win_rd_q;
  logic [WEIGHT_W-1:0] wgt_rd_q;
  logic win_we, wgt_we;

  logic div_start, div_done;
  logic [63:0] div_dvd, div_dvs, div_quo;
  logic sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;

  logic signed [COORD_BITS-1:0] rd_x, rd_y, pt_x, pt_y, c_sel;
  logic signed [COORD_BITS:0] dx, dy, px_diff, py_diff;
  logic [COORD_BITS:0] ux, uy, um;
  logic signed [63:0] acc_sel;
  logic acc_neg;
  logic [63:0] acc_abs;
  logic signed [SAT_W-1:0] q_signed, c_ext;
  logic cfg_we;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW_LENGTH:   prdata = {27'b0, wl_q};
      REG_ITERATION_COUNT: prdata = {27'b0, iter_q};
      REG_JUMP_THRESHOLD:  prdata = {1'b0, thr_q};
      default:             prdata = '0;
    endcase
  end

  // effective window length and ring write position
  always_comb begin
    if (wl_q == 5'd0) begin
      len = CNT_W'(1);
    end else if (32'(wl_q) > WINDOW_DEPTH) begin
      len = CNT_W'(WINDOW_DEPTH);
    end else begin
      len = CNT_W'(wl_q);
    end
  end

  assign slot     = (CNT_W'(ws_q) >= len) ? '0 : ws_q;
  assign slot_inc = CNT_W'(slot) + CNT_W'(1);
  assign ws_n     = (slot_inc == len) ? '0 : slot_inc[IDX_W-1:0];
  assign fill_n   = (fill_q < len) ? fill_q + CNT_W'(1) : fill_q;

  assign rd_x = win_rd_q[COORD_BITS-1:0];
  assign rd_y = win_rd_q[2*COORD_BITS-1:COORD_BITS];
  assign pt_x = jmode_q ? p_q[COORD_BITS-1:0] : rd_x;
  assign pt_y = jmode_q ? p_q[2*COORD_BITS-1:COORD_BITS] : rd_y;

  assign dx = {pt_x[COORD_BITS-1], pt_x} - {cx_q[COORD_BITS-1], cx_q};
  assign dy = {pt_y[COORD_BITS-1], pt_y} - {cy_q[COORD_BITS-1], cy_q};
  assign ux = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
  assign uy = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
  assign um = ux | uy;

  assign px_diff = {rd_x[COORD_BITS-1], rd_x} - {cx_q[COORD_BITS-1], cx_q};
  assign py_diff = {rd_y[COORD_BITS-1], rd_y} - {cy_q[COORD_BITS-1], cy_q};

  assign ws = WEIGHT_BITS'(64'(wgt_rd_q) >> t_q);

  assign acc_sel  = yflag_q ? acc_y_q : acc_x_q;
  assign acc_neg  = acc_sel[63];
  assign acc_abs  = acc_neg ? (~acc_sel + 64'd1) : acc_sel;
  assign q_signed = acc_neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
  assign c_sel    = yflag_q ? cy_q : cx_q;
  assign c_ext    = SAT_W'(c_sel);
  assign dist_new = DIST_W'(sqrt_root) << ds_q;

  always_comb begin
    state_d     = state_q;
    wl_d        = wl_q;
    iter_d      = iter_q;
    thr_d       = thr_q;
    fill_d      = fill_q;
    ws_d        = ws_q;
    idx_d       = idx_q;
    it_d        = it_q;
    t_d         = t_q;
    yflag_d     = yflag_q;
    jmode_d     = jmode_q;
    p_d         = p_q;
    acc_x_d     = acc_x_q;
    acc_y_d     = acc_y_q;
    tot_d       = tot_q;
    wsum_d      = wsum_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    res_x_d     = res_x_q;
    res_y_d     = res_y_q;
    res_jump_d  = res_jump_q;
    da_d        = da_q;
    db_d        = db_q;
    ds_d        = ds_q;
    sqa_d       = sqa_q;
    dist_d      = dist_q;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    div_dvd     = acc_abs;
    div_dvs     = 64'(fill_q);
    sqrt_start  = 1'b0;
    win_we      = 1'b0;
    wgt_we      = 1'b0;
    out_load    = 1'b0;

    if (cfg_we) begin
      unique case (paddr[3:2])
        REG_WINDOW_LENGTH: begin
          wl_d   = pwdata[4:0];
          ws_d   = '0;
          fill_d = '0;
        end
        REG_ITERATION_COUNT: iter_d = pwdata[4:0];
        REG_JUMP_THRESHOLD:  thr_d  = pwdata[30:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          p_d = {sample_i.pos_y, sample_i.pos_x};
          if (sample_i.cmd == CMD_CLEAR) begin
            ws_d   = '0;
            fill_d = '0;
          end else begin
            win_we = 1'b1;
            ws_d   = ws_n;
            fill_d = fill_n;
            if (fill_n == CNT_W'(1)) begin
              res_x_d    = sample_i.pos_x;
              res_y_d    = sample_i.pos_y;
              res_jump_d = 1'b0;
              state_d    = ST_DONE;
            end else begin
              idx_d   = '0;
              acc_x_d = '0;
              acc_y_d = '0;
              yflag_d = 1'b0;
              jmode_d = 1'b0;
              state_d = ST_MEAN_RD;
            end
          end
        end
      end
      ST_MEAN_RD: state_d = ST_MEAN_ACC;
      ST_MEAN_ACC: begin
        acc_x_d = acc_x_q + 64'(rd_x);
        acc_y_d = acc_y_q + 64'(rd_y);
        idx_d   = idx_q + CNT_W'(1);
        state_d = (idx_q + CNT_W'(1) == fill_q) ? ST_MEAN_DIV : ST_MEAN_RD;
      end
      ST_MEAN_DIV: begin
        div_start = 1'b1;
        state_d   = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          if (!yflag_q) begin
            cx_d    = sat_coord(q_signed);
            yflag_d = 1'b1;
            state_d = ST_MEAN_DIV;
          end else begin
            cy_d    = sat_coord(q_signed);
            it_d    = '0;
            state_d = ST_ITER;
          end
        end
      end
      ST_ITER: begin
        if (it_q == iter_q) begin
          state_d = ST_JUMP;
        end else begin
          idx_d   = '0;
          tot_d   = '0;
          state_d = ST_P1_RD;
        end
      end
      ST_P1_RD: state_d = ST_DIST;
      ST_DIST: begin
        // smallest shift that brings both offsets below 2^31
        if (um[COORD_BITS]) begin
          ds_d = 2'd2;
          da_d = ux[COORD_BITS:2];
          db_d = uy[COORD_BITS:2];
        end else if (um[COORD_BITS-1]) begin
          ds_d = 2'd1;
          da_d = ux[COORD_BITS-1:1];
          db_d = uy[COORD_BITS-1:1];
        end else begin
          ds_d = 2'd0;
          da_d = ux[DIST_OP_W-1:0];
          db_d = uy[DIST_OP_W-1:0];
        end
        state_d = ST_SQA;
      end
      ST_SQA: begin
        mul_a   = {{(MUL_W-DIST_OP_W){1'b0}}, da_q};
        mul_b   = {{(MUL_W-DIST_OP_W){1'b0}}, da_q};
        state_d = ST_SQB;
      end
      ST_SQB: begin
        sqa_d   = prod_q[61:0];
        mul_a   = {{(MUL_W-DIST_OP_W){1'b0}}, db_q};
        mul_b   = {{(MUL_W-DIST_OP_W){1'b0}}, db_q};
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        sqrt_start = 1'b1;
        state_d    = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          if (jmode_q) begin
            if (dist_new > DIST_W'(thr_q)) begin
              ws_d       = '0;
              fill_d     = '0;
              res_x_d    = p_q[COORD_BITS-1:0];
              res_y_d    = p_q[2*COORD_BITS-1:COORD_BITS];
              res_jump_d = 1'b1;
            end else begin
              res_x_d    = cx_q;
              res_y_d    = cy_q;
              res_jump_d = 1'b0;
            end
            state_d = ST_DONE;
          end else begin
            dist_d  = dist_new;
            state_d = ST_WDIV;
          end
        end
      end
      ST_WDIV: begin
        div_start = 1'b1;
        div_dvd   = WEIGHT_DIVIDEND;
        div_dvs   = 64'((dist_q < MIN_DIST) ? MIN_DIST : dist_q);
        state_d   = ST_WDIV_WAIT;
      end
      ST_WDIV_WAIT: begin
        if (div_done) begin
          wgt_we  = 1'b1;
          tot_d   = tot_q + div_quo;
          idx_d   = idx_q + CNT_W'(1);
          t_d     = '0;
          state_d = (idx_q + CNT_W'(1) == fill_q) ? ST_TSHIFT : ST_P1_RD;
        end
      end
      ST_TSHIFT: begin
        // scale the weights until their sum fits the weight width
        if (|tot_q[63:WEIGHT_BITS]) begin
          tot_d = tot_q >> 1;
          t_d   = t_q + 6'd1;
        end else begin
          idx_d   = '0;
          acc_x_d = '0;
          acc_y_d = '0;
          wsum_d  = '0;
          state_d = ST_P2_RD;
        end
      end
      ST_P2_RD: state_d = ST_P2_MULX;
      ST_P2_MULX: begin
        mul_a   = {{(MUL_W-WEIGHT_BITS){1'b0}}, ws};
        mul_b   = {{(MUL_W-COORD_BITS-1){px_diff[COORD_BITS]}}, px_diff};
        state_d = ST_P2_MULY;
      end
      ST_P2_MULY: begin
        acc_x_d = acc_x_q + prod_q[63:0];
        mul_a   = {{(MUL_W-WEIGHT_BITS){1'b0}}, ws};
        mul_b   = {{(MUL_W-COORD_BITS-1){py_diff[COORD_BITS]}}, py_diff};
        state_d = ST_P2_ACC;
      end
      ST_P2_ACC: begin
        acc_y_d = acc_y_q + prod_q[63:0];
        wsum_d  = wsum_q + ws;
        idx_d   = idx_q + CNT_W'(1);
        state_d = (idx_q + CNT_W'(1) == fill_q) ? ST_P2_END : ST_P2_RD;
      end
      ST_P2_END: begin
        if (wsum_q == '0) begin
          state_d = ST_JUMP;
        end else begin
          yflag_d = 1'b0;
          state_d = ST_STEP_DIV;
        end
      end
      ST_STEP_DIV: begin
        div_start = 1'b1;
        div_dvs   = 64'(wsum_q);
        state_d   = ST_STEP_WAIT;
      end
      ST_STEP_WAIT: begin
        div_dvs = 64'(wsum_q);
        if (div_done) begin
          if (!yflag_q) begin
            cx_d    = sat_coord(c_ext + q_signed);
            yflag_d = 1'b1;
            state_d = ST_STEP_DIV;
          end else begin
            cy_d    = sat_coord(c_ext + q_signed);
            it_d    = it_q + 5'd1;
            state_d = ST_ITER;
          end
        end
      end
      ST_JUMP: begin
        jmode_d = 1'b1;
        state_d = ST_DIST;
      end
      ST_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wl_q        <= 5'd10;
      iter_q      <= 5'd10;
      thr_q       <= '0;
      fill_q      <= '0;
      ws_q        <= '0;
      idx_q       <= '0;
      it_q        <= '0;
      t_q         <= '0;
      yflag_q     <= 1'b0;
      jmode_q     <= 1'b0;
      out_valid_q <= 1'b0;
      p_q         <= '0;
    end else begin
      state_q     <= state_d;
      wl_q        <= wl_d;
      iter_q      <= iter_d;
      thr_q       <= thr_d;
      fill_q      <= fill_d;
      ws_q        <= ws_d;
      idx_q       <= idx_d;
      it_q        <= it_d;
      t_q         <= t_d;
      yflag_q     <= yflag_d;
      jmode_q     <= jmode_d;
      out_valid_q <= out_valid_d;
      p_q         <= p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_x_q    <= acc_x_d;
    acc_y_q    <= acc_y_d;
    tot_q      <= tot_d;
    wsum_q     <= wsum_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    res_x_q    <= res_x_d;
    res_y_q    <= res_y_d;
    res_jump_q <= res_jump_d;
    da_q       <= da_d;
    db_q       <= db_d;
    ds_q       <= ds_d;
    sqa_q      <= sqa_d;
    dist_q     <= dist_d;
    prod_q     <= mul_a * mul_b;
    if (out_load) begin
      out_x_q    <= res_x_q;
      out_y_q    <= res_y_q;
      out_jump_q <= res_jump_q;
    end
  end

  // sample window and per-point weights
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[slot] <= {sample_i.pos_y, sample_i.pos_x};
    end
    win_rd_q <= win_mem[idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wgt_we) begin
      wgt_mem[idx_q[IDX_W-1:0]] <= div_quo[WEIGHT_W-1:0];
    end
    wgt_rd_q <= wgt_mem[idx_q[IDX_W-1:0]];
  end

  wgmf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  wgmf_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (63'(sqa_q) + prod_q[62:0]),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  assign sample_i.ready      = (state_q == ST_IDLE);
  assign result_o.valid      = out_valid_q;
  assign result_o.out_x      = out_x_q;
  assign result_o.out_y      = out_y_q;
  assign result_o.jump_reset = out_jump_q;

  `WGMF_ASSERT_HOLDS(a_fill_within_len, 1'b1, fill_q <= len, "fill level beyond window length")
  `WGMF_ASSERT_HOLDS(a_slot_within_len, 1'b1, CNT_W'(ws_q) < len, "write slot beyond window length")
  `WGMF_ASSERT_HOLDS(a_div_done_awaited, div_done,
    state_q == ST_MEAN_WAIT || state_q == ST_WDIV_WAIT || state_q == ST_STEP_WAIT,
    "divider finished outside a wait state")
  `WGMF_ASSERT_HOLDS(a_sqrt_done_awaited, sqrt_done, state_q == ST_SQRT_WAIT,
    "square root finished outside its wait state")
  `WGMF_ASSERT_NEXT(a_step_nonzero_weight, state_q == ST_STEP_DIV, wsum_q != '0,
    "weiszfeld step with zero weight sum")

endmodule
`default_nettype wire
